@@ rtl/core/fp8sq_pkg.sv @@
package fp8sq_pkg;

   localparam int GEN_COUNT = 16;
   localparam int ELEMS_PER_GEN = 16;
   localparam int GEN_W = (GEN_COUNT > 1) ? $clog2(GEN_COUNT) : 1;
   localparam int IDX_TOTAL = GEN_COUNT * ELEMS_PER_GEN;
   localparam int IDX_W = (IDX_TOTAL > 1) ? $clog2(IDX_TOTAL) : 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [31:0] ONE_FP32 = 32'h3F80_0000;
   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

   localparam logic [15:0] HALF_QNAN = 16'h7E00;
   localparam logic [15:0] HALF_EXP_MASK = 16'h7C00;
   localparam logic [15:0] HALF_TOP_MASK = 16'h7F00;
   localparam logic [15:0] HALF_ROUND_LIMIT = 16'h7B00;
   localparam logic [15:0] HALF_EXP_MAX_ROUND = 16'h7800;
   localparam logic [15:0] HALF_EXP_MIN_NORMAL = 16'h0400;
   localparam logic [15:0] HALF_LOW_MASK = 16'h00FF;
   localparam logic [15:0] HALF_TIE_MASK = 16'h0180;
   localparam logic [15:0] HALF_HALF_LSB = 16'h0080;
   localparam logic [15:0] HALF_KEPT_LSB = 16'h0100;
   localparam logic [15:0] HALF_KEPT_MASK = 16'hFF00;

   localparam logic [31:0] SEED_TABLE [16][4] = '{
      '{32'd1387366120, 32'd2798441831, 32'd888998500, 32'd1099633400},
      '{32'd2034269327, 32'd2125325156, 32'd1209715489, 32'd1931656721},
      '{32'd1555452618, 32'd650181557, 32'd883695203, 32'd627677842},
      '{32'd4195248041, 32'd2146478152, 32'd480059239, 32'd1468956197},
      '{32'd1252084877, 32'd500390994, 32'd977516591, 32'd1950666000},
      '{32'd3936597502, 32'd834151069, 32'd1477014702, 32'd734008143},
      '{32'd1983400973, 32'd1164103095, 32'd2110188261, 32'd2019272068},
      '{32'd1877096364, 32'd2833629967, 32'd4196320416, 32'd1774181187},
      '{32'd702309618, 32'd4077815558, 32'd1512057936, 32'd1868769368},
      '{32'd510001215, 32'd966559856, 32'd776583255, 32'd1475621065},
      '{32'd1271806057, 32'd1881312534, 32'd478635452, 32'd814821902},
      '{32'd733990058, 32'd1889991804, 32'd1108257970, 32'd1093480892},
      '{32'd4273743809, 32'd4167473370, 32'd558000409, 32'd1594848927},
      '{32'd444870959, 32'd1595722866, 32'd1064124488, 32'd3637102547},
      '{32'd703721499, 32'd3896407831, 32'd1002360059, 32'd1427395742},
      '{32'd1295231497, 32'd1254972431, 32'd1423497865, 32'd861918264}
   };

   typedef struct packed {
      logic [31:0] value_bits;
      logic        last_of_block;
   } item_type;

   // fp32 pattern to fp16 pattern, round to nearest even.
   function automatic logic [15:0] to_half(input logic [31:0] f);
      logic               sign;
      logic [7:0]         e;
      logic [22:0]        m;
      logic signed [9:0]  he;
      logic [15:0]        h;
      logic [12:0]        rem;
      logic [23:0]        sig;
      logic [9:0]         shw;
      logic [4:0]         sh;
      logic [23:0]        q;
      logic [23:0]        remb;
      logic [23:0]        halfb;
      sign = f[31];
      e = f[30:23];
      m = f[22:0];
      he = $signed({2'b00, e}) - 10'sd112;
      h = {sign, 15'd0};
      if (e == 8'hFF) begin
         h = (m != 23'd0) ? HALF_QNAN : ({sign, 15'd0} | HALF_EXP_MASK);
      end else if (he >= 10'sd31) begin
         h = {sign, 15'd0} | HALF_EXP_MASK;
      end else if (he >= 10'sd1) begin
         h = {sign, he[4:0], m[22:13]};
         rem = m[12:0];
         if (rem > 13'h1000 || (rem == 13'h1000 && h[0])) begin
            h = h + 16'd1;
         end
      end else if (e == 8'd0 || he < -10'sd10) begin
         h = {sign, 15'd0};
      end else begin
         sig = {1'b1, m};
         shw = 10'(10'sd14 - he);
         sh = shw[4:0];
         q = sig >> sh;
         remb = sig & ((24'd1 << sh) - 24'd1);
         halfb = 24'd1 << (sh - 5'd1);
         h = {sign, q[14:0]};
         if (remb > halfb || (remb == halfb && q[0])) begin
            h = h + 16'd1;
         end
      end
      return h;
   endfunction

   // Stochastic rounding of normals, nearest even for subnormals, low byte cleared.
   function automatic logic [15:0] quantize(input logic [15:0] h_in, input logic [7:0] rnd);
      logic [15:0] h;
      logic [15:0] ex;
      logic        round_ok;
      h = h_in;
      ex = h_in & HALF_EXP_MASK;
      round_ok = (h_in & HALF_TOP_MASK) <= HALF_ROUND_LIMIT;
      if (ex != HALF_EXP_MASK && round_ok) begin
         if (ex >= HALF_EXP_MIN_NORMAL && ex <= HALF_EXP_MAX_ROUND) begin
            h = h_in + {8'd0, rnd};
         end else if (ex == 16'd0 && ((h_in & HALF_LOW_MASK) > HALF_HALF_LSB
                      || (h_in & HALF_TIE_MASK) == HALF_TIE_MASK)) begin
            h = h_in + HALF_KEPT_LSB;
         end
      end
      return h & HALF_KEPT_MASK;
   endfunction

   // E5M2 code widened exactly to an fp32 pattern.
   function automatic logic [31:0] widen(input logic [7:0] code);
      logic [31:0] w;
      logic        sign;
      logic [4:0]  e;
      logic [1:0]  q;
      sign = code[7];
      e = code[6:2];
      q = code[1:0];
      if (e == 5'h1F) begin
         w = (q != 2'd0) ? CANON_NAN : {sign, 8'hFF, 23'd0};
      end else if (e != 5'd0) begin
         w = {sign, 8'({3'd0, e} + 8'd112), q, 21'd0};
      end else begin
         case (q)
            2'd1: w = {sign, 8'd111, 23'd0};
            2'd2: w = {sign, 8'd112, 23'd0};
            2'd3: w = {sign, 8'd112, 2'b10, 21'd0};
            default: w = {sign, 31'd0};
         endcase
      end
      return w;
   endfunction

endpackage

@@ rtl/core/fp8_e5m2_stochastic_quantizer.sv @@
// FP8 E5M2 stochastic quantizer. Each fp32 element is scaled, converted to fp16, rounded
// to E5M2 with random bits from sixteen xoshiro128+ generators (nearest even for
// subnormals), and returned as the FP8 code together with its value times the inverse
// scale. The back end takes the next element only once the previous result has entered
// the result register. Both fp32 products go through one shared multiplier, whose
// normalization shifts one bit per cycle, so a subnormal operand needs more shifts; a
// zero, infinite or NaN operand skips the normalization. A full result register holds
// the back end until it is popped. A two-entry input queue and a one-entry result
// register let the source and the sink stall independently. Scale registers sit at
// byte addresses 0 and 4; the user must write them only while no transaction is in
// flight, and the block itself does not enforce this.
module fp8_e5m2_stochastic_quantizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_value_bits,
   input  logic        req_last_of_block,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_result_bits,
   output logic [7:0]  rsp_fp8_code,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import fp8sq_pkg::*;

   localparam logic REG_SCALE = 1'b0;
   localparam logic REG_INV_SCALE = 1'b1;

   logic [31:0] scale_ff, scale_in;
   logic [31:0] inv_ff, inv_in;
   logic        csr_write;
   item_type    req_item, queue_item;
   logic        queue_valid, queue_ready;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      scale_in = scale_ff;
      inv_in = inv_ff;
      prdata = scale_ff;
      unique case (paddr[2])
         REG_SCALE: begin
            prdata = scale_ff;
            if (csr_write) scale_in = pwdata;
         end
         REG_INV_SCALE: begin
            prdata = inv_ff;
            if (csr_write) inv_in = pwdata;
         end
         default: prdata = scale_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= ONE_FP32;
         inv_ff <= ONE_FP32;
      end else begin
         scale_ff <= scale_in;
         inv_ff <= inv_in;
      end
   end

   assign req_item.value_bits = req_value_bits;
   assign req_item.last_of_block = req_last_of_block;

   fp8sq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .in_item   (req_item),
      .full      (full),
      .out_item  (queue_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready)
   );

   fp8sq_back u_back (
      .clock              (clock),
      .reset              (reset),
      .in_item            (queue_item),
      .in_valid           (queue_valid),
      .in_ready           (queue_ready),
      .scale_bits         (scale_ff),
      .inverse_scale_bits (inv_ff),
      .pop                (pop),
      .empty              (empty),
      .result_bits        (rsp_result_bits),
      .fp8_code           (rsp_fp8_code)
   );

   // A NaN code always dequantizes to the canonical NaN.
   a_nan_code: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_fp8_code[6:2] == 5'h1F && rsp_fp8_code[1:0] != 2'd0)
      |-> rsp_result_bits == CANON_NAN)
      else $error("NaN code without canonical NaN result");

   // An infinity code gives infinity or NaN after scaling.
   a_inf_code: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_fp8_code[6:0] == 7'h7C) |-> rsp_result_bits[30:23] == 8'hFF)
      else $error("infinity code with finite result");

   // A zero code gives a signed zero or NaN.
   a_zero_code: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_fp8_code[6:0] == 7'd0)
      |-> (rsp_result_bits[30:0] == 31'd0 || rsp_result_bits == CANON_NAN))
      else $error("zero code with nonzero result");

endmodule

@@ rtl/core/fp8sq_fmul.sv @@
module fp8sq_fmul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic        done,
   output logic [31:0] y
);
   import fp8sq_pkg::*;

   typedef enum logic [1:0] {F_IDLE, F_NORM, F_FIN} state_type;

   state_type          state_ff, state_in;
   logic [47:0]        p_ff, p_in;
   logic signed [10:0] x_ff, x_in;
   logic               sign_ff, sign_in;
   logic               done_ff, done_in;
   logic [31:0]        y_ff, y_in;

   logic [7:0]         ea, eb, eaa, ebb;
   logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic signed [10:0] x_sum;

   logic               under;
   logic signed [10:0] dx;
   logic [6:0]         shamt;
   logic [47:0]        q;
   logic               lost;
   logic signed [10:0] xe, xr;
   logic [23:0]        mant, mfin;
   logic [24:0]        m25;
   logic               grd, stk, inc;
   logic [31:0]        packed_y;

   assign ea = a[30:23];
   assign eb = b[30:23];
   assign a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
   assign b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
   assign a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
   assign b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
   assign a_zero = (ea == 8'd0) && (a[22:0] == 23'd0);
   assign b_zero = (eb == 8'd0) && (b[22:0] == 23'd0);
   assign eaa = (ea == 8'd0) ? 8'd1 : ea;
   assign ebb = (eb == 8'd0) ? 8'd1 : eb;
   // Exponent of product bit 47.
   assign x_sum = $signed({3'd0, eaa}) + $signed({3'd0, ebb}) - 11'sd126;

   // Results below the normal range are shifted right to the subnormal scale.
   assign under = x_ff < 11'sd1;
   assign dx = 11'sd1 - x_ff;
   assign shamt = !under ? 7'd0 : ((dx > 11'sd48) ? 7'd48 : dx[6:0]);
   assign q = p_ff >> shamt;
   assign lost = |(p_ff & ~({48{1'b1}} << shamt));
   assign xe = under ? 11'sd1 : x_ff;
   assign mant = q[47:24];
   assign grd = q[23];
   assign stk = (|q[22:0]) | lost;
   assign inc = grd & (stk | mant[0]);
   assign m25 = {1'b0, mant} + {24'd0, inc};
   assign mfin = m25[24] ? m25[24:1] : m25[23:0];
   assign xr = m25[24] ? (xe + 11'sd1) : xe;

   always_comb begin
      if (xr >= 11'sd255) begin
         packed_y = {sign_ff, 8'hFF, 23'd0};
      end else begin
         packed_y = {sign_ff, (mfin[23] ? xr[7:0] : 8'd0), mfin[22:0]};
      end
   end

   always_comb begin
      state_in = state_ff;
      p_in = p_ff;
      x_in = x_ff;
      sign_in = sign_ff;
      done_in = 1'b0;
      y_in = y_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               sign_in = a[31] ^ b[31];
               if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
                  y_in = CANON_NAN;
                  done_in = 1'b1;
               end else if (a_inf || b_inf) begin
                  y_in = {a[31] ^ b[31], 8'hFF, 23'd0};
                  done_in = 1'b1;
               end else if (a_zero || b_zero) begin
                  y_in = {a[31] ^ b[31], 31'd0};
                  done_in = 1'b1;
               end else begin
                  p_in = {ea != 8'd0, a[22:0]} * {eb != 8'd0, b[22:0]};
                  x_in = x_sum;
                  state_in = F_NORM;
               end
            end
         end
         F_NORM: begin
            if (!p_ff[47] && x_ff > 11'sd1) begin
               p_in = p_ff << 1;
               x_in = x_ff - 11'sd1;
            end else begin
               state_in = F_FIN;
            end
         end
         F_FIN: begin
            y_in = packed_y;
            done_in = 1'b1;
            state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      p_ff <= p_in;
      x_ff <= x_in;
      sign_ff <= sign_in;
      y_ff <= y_in;
   end

   assign done = done_ff;
   assign y = y_ff;

endmodule

@@ rtl/core/fp8sq_rng.sv @@
module fp8sq_rng (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [fp8sq_pkg::GEN_W-1:0] gen_sel,
   input  logic                        step,
   output logic [31:0]                 rnd
);
   import fp8sq_pkg::*;

   // Row layout: word 3 in the top bits, word 0 in the bottom bits.
   logic [127:0] row_ff [GEN_COUNT];
   logic [127:0] row_in;
   logic [31:0]  s0, s1, s2, s3, t, n0, n1, n2, n3;

   always_comb begin
      {s3, s2, s1, s0} = row_ff[gen_sel];
      t = s1 << 9;
      n2 = s2 ^ s0;
      n3 = s3 ^ s1;
      n1 = s1 ^ n2;
      n0 = s0 ^ n3;
      n2 = n2 ^ t;
      n3 = {n3[20:0], n3[31:21]};
      row_in = {n3, n2, n1, n0};
   end

   assign rnd = s0 + s3;

   always_ff @(posedge clock) begin
      for (int g = 0; g < GEN_COUNT; g++) begin
         if (reset) begin
            row_ff[g] <= {SEED_TABLE[g % 16][3], SEED_TABLE[g % 16][2],
                          SEED_TABLE[g % 16][1], SEED_TABLE[g % 16][0]};
         end else if (step && gen_sel == GEN_W'(g)) begin
            row_ff[g] <= row_in;
         end
      end
   end

endmodule

@@ rtl/core/fp8sq_front.sv @@
module fp8sq_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fp8sq_pkg::item_type  in_item,
   output logic                 full,
   output fp8sq_pkg::item_type  out_item,
   output logic                 out_valid,
   input  logic                 out_ready
);
   import fp8sq_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = out_valid && out_ready;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

endmodule

@@ rtl/core/fp8sq_back.sv @@
module fp8sq_back (
   input  logic                clock,
   input  logic                reset,
   input  fp8sq_pkg::item_type in_item,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [31:0]         scale_bits,
   input  logic [31:0]         inverse_scale_bits,
   input  logic                pop,
   output logic                empty,
   output logic [31:0]         result_bits,
   output logic [7:0]          fp8_code
);
   import fp8sq_pkg::*;

   typedef enum logic [2:0] {B_IDLE, B_MUL1, B_QUANT, B_WIDE, B_MUL2, B_OUT} state_type;

   state_type        state_ff, state_in;
   logic             last_ff, last_in;
   logic [15:0]      half_ff, half_in;
   logic [7:0]       code_ff, code_in;
   logic [31:0]      wide_ff, wide_in;
   logic [31:0]      res_ff, res_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             full_ff, full_in;
   logic [31:0]      out_res_ff, out_res_in;
   logic [7:0]       out_code_ff, out_code_in;

   logic             mul_start, mul_done;
   logic [31:0]      mul_a, mul_b, mul_y;
   logic             rng_step;
   logic [31:0]      rnd;
   logic [GEN_W-1:0] gen_sel;
   logic [15:0]      hq;
   logic [IDX_W:0]   idx_inc;

   assign gen_sel = GEN_W'((idx_ff / ELEMS_PER_GEN) % GEN_COUNT);
   assign hq = quantize(half_ff, rnd[7:0]);
   assign idx_inc = {1'b0, idx_ff} + (IDX_W + 1)'(1);

   fp8sq_fmul u_fmul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .y     (mul_y)
   );

   fp8sq_rng u_rng (
      .clock   (clock),
      .reset   (reset),
      .gen_sel (gen_sel),
      .step    (rng_step),
      .rnd     (rnd)
   );

   assign in_ready = (state_ff == B_IDLE);
   assign mul_start = (state_ff == B_IDLE && in_valid) || (state_ff == B_WIDE);
   assign mul_a = (state_ff == B_IDLE) ? in_item.value_bits : wide_ff;
   assign mul_b = (state_ff == B_IDLE) ? scale_bits : inverse_scale_bits;
   // Every finite half value advances its generator, used or not.
   assign rng_step = (state_ff == B_QUANT) && ((half_ff & HALF_EXP_MASK) != HALF_EXP_MASK);

   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      half_in = half_ff;
      code_in = code_ff;
      wide_in = wide_ff;
      res_in = res_ff;
      idx_in = idx_ff;
      full_in = full_ff;
      out_res_in = out_res_ff;
      out_code_in = out_code_ff;
      if (pop && full_ff) begin
         full_in = 1'b0;
      end
      unique case (state_ff)
         B_IDLE: begin
            if (in_valid) begin
               last_in = in_item.last_of_block;
               state_in = B_MUL1;
            end
         end
         B_MUL1: begin
            if (mul_done) begin
               half_in = to_half(mul_y);
               state_in = B_QUANT;
            end
         end
         B_QUANT: begin
            code_in = hq[15:8];
            wide_in = widen(hq[15:8]);
            if (last_ff || idx_inc == (IDX_W + 1)'(IDX_TOTAL)) begin
               idx_in = '0;
            end else begin
               idx_in = idx_inc[IDX_W-1:0];
            end
            state_in = B_WIDE;
         end
         B_WIDE: begin
            state_in = B_MUL2;
         end
         B_MUL2: begin
            if (mul_done) begin
               if (mul_y[30:23] == 8'hFF && mul_y[22:0] != 23'd0) begin
                  res_in = CANON_NAN;
               end else begin
                  res_in = mul_y;
               end
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (!full_ff || pop) begin
               out_res_in = res_ff;
               out_code_in = code_ff;
               full_in = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         idx_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         full_ff <= full_in;
      end
      last_ff <= last_in;
      half_ff <= half_in;
      code_ff <= code_in;
      wide_ff <= wide_in;
      res_ff <= res_in;
      out_res_ff <= out_res_in;
      out_code_ff <= out_code_in;
   end

   assign empty = !full_ff;
   assign result_bits = out_res_ff;
   assign fp8_code = out_code_ff;

endmodule
